[src/srv_pkg.sv]
// ----------------------------------------------------------------------------
// Stroke ribbon vertex generator package
// Shared types and constants for the vertex generator and its iterative unit.
// ----------------------------------------------------------------------------
package srv_pkg;

    localparam int OPW      = 58;   // operand shift register
    localparam int RW       = 33;   // partial remainder
    localparam int QW       = 39;   // quotient / root
    localparam int DVW      = 30;   // divisor (2 * len_q)
    localparam int LQW      = 29;   // len_q
    localparam int MAG_W    = 16;   // reduced direction magnitude
    localparam int HW_W     = 18;   // half width * 512
    localparam int MUL_W    = 19;   // signed multiplier operand
    localparam int PROD_W   = 38;
    localparam int CNT_W    = 6;

    localparam logic [CNT_W-1:0] SQ_STEPS = 6'd29;
    localparam logic [CNT_W-1:0] DV_STEPS = 6'd39;

    localparam logic [8:0] PRESS_FULL = 9'd256;
    localparam logic [9:0] MIN_RESET  = 10'd32;
    localparam logic [9:0] MAX_RESET  = 10'd128;

    localparam logic REG_MIN_WIDTH = 1'b0;
    localparam logic REG_MAX_WIDTH = 1'b1;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } unit_cmd_t;

endpackage

[src/stroke_ribbon_vertex_gen.sv]
// ----------------------------------------------------------------------------
// Stroke ribbon vertex generator
// Turns stroke points into triangle-strip vertex pairs offset by the scaled
// unit perpendicular of the local direction.
// ----------------------------------------------------------------------------
// Sequence: an accepted request runs a square root, two divides and the setup,
// multiply and handoff states before its first vertex, with one more reduction pass per
// halving of an oversized direction; a closing point repeats that for its second pair.
// Throughput: one request at a time; a point that is only held is stored without
// running that sequence, and output stalls hold the emitting states.
// Reset: rst_n asynchronous; clears the held points, widths go to 32 and 128.
module stroke_ribbon_vertex_gen
#(
    parameter int COORD_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic [8:0]                    pressure,
    input  logic                          stroke_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] vertex_x,
    output logic signed [COORD_WIDTH-1:0] vertex_y,
    output logic                          side,
    output logic                          last_of_run,
    output logic                          strip_done
);

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int MW = (DW > srv_pkg::MAG_W + 1) ? DW : srv_pkg::MAG_W + 1;
    localparam int SW = ((CW > srv_pkg::QW) ? CW : srv_pkg::QW) + 2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIR, ST_RED, ST_MHW, ST_MXX, ST_MYY, ST_SQL, ST_SQW,
        ST_MY, ST_DVYW, ST_MX, ST_DVXW, ST_EM0, ST_EM1, ST_EM2
    } state_t;

    state_t state_reg;

    logic [9:0] min_width_reg, max_width_reg;

    logic signed [CW-1:0] in_x_reg, in_y_reg, held_x_reg, held_y_reg;
    logic signed [CW-1:0] prior_x_reg, prior_y_reg, pt_x_reg, pt_y_reg;
    logic [8:0]           in_p_reg, held_p_reg, pt_p_reg;
    logic                 in_end_reg;
    logic [1:0]           seen_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [MW-1:0]        ax_reg, ay_reg;
    logic                 negx_reg, negy_reg, job2_reg, run_end_reg, done_flag_reg;
    logic signed [srv_pkg::PROD_W-1:0] prod_reg;
    logic [31:0]          acc_reg;
    logic [srv_pkg::HW_W-1:0] hw_reg;
    logic [srv_pkg::LQW-1:0]  lq_reg;
    logic [srv_pkg::QW-1:0]   qx_reg, qy_reg;

    logic signed [CW-1:0] vx_reg, vy_reg;
    logic                 side_reg, last_reg, sdone_reg, ovalid_reg;

    // ---------------- configuration ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = {22'd0, (paddr[2] == srv_pkg::REG_MAX_WIDTH) ? max_width_reg
                                                                 : min_width_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_width_reg <= srv_pkg::MIN_RESET;
            max_width_reg <= srv_pkg::MAX_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                srv_pkg::REG_MIN_WIDTH: min_width_reg <= pwdata[9:0];
                srv_pkg::REG_MAX_WIDTH: max_width_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // ---------------- shared multiplier ----------------
    logic signed [srv_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [srv_pkg::PROD_W-1:0] mul_p;
    logic signed [10:0] span;

    always_comb
    begin
        span  = $signed({1'b0, max_width_reg}) - $signed({1'b0, min_width_reg});
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MHW:
            begin
                mul_a = $signed({10'd0, pt_p_reg});
                mul_b = srv_pkg::MUL_W'(span);
            end
            ST_MXX:
            begin
                mul_a = $signed({3'd0, ax_reg[srv_pkg::MAG_W-1:0]});
                mul_b = mul_a;
            end
            ST_MYY:
            begin
                mul_a = $signed({3'd0, ay_reg[srv_pkg::MAG_W-1:0]});
                mul_b = mul_a;
            end
            ST_MY:
            begin
                mul_a = $signed({3'd0, ay_reg[srv_pkg::MAG_W-1:0]});
                mul_b = $signed({1'b0, hw_reg});
            end
            ST_MX:
            begin
                mul_a = $signed({3'd0, ax_reg[srv_pkg::MAG_W-1:0]});
                mul_b = $signed({1'b0, hw_reg});
            end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // ---------------- iterative unit ----------------
    srv_pkg::unit_cmd_t        ucmd;
    logic [srv_pkg::OPW-1:0]   u_operand;
    logic [srv_pkg::DVW-1:0]   u_divisor;
    logic                      u_done;
    logic [srv_pkg::QW-1:0]    u_result;
    logic [32:0]               sumsq;
    logic [srv_pkg::QW-1:0]    dividend;

    always_comb
    begin
        sumsq    = {1'b0, acc_reg} + {1'b0, prod_reg[31:0]};
        dividend = {1'b0, prod_reg[33:0], 4'd0} + {10'd0, lq_reg};
        ucmd.start     = (state_reg == ST_SQL) || (state_reg == ST_MY)
                      || (state_reg == ST_MX);
        ucmd.sqrt_mode = (state_reg == ST_SQL);
        if (state_reg == ST_SQL)
            u_operand = {1'b0, sumsq, 24'd0};
        else
            u_operand = {dividend, {(srv_pkg::OPW-srv_pkg::QW){1'b0}}};
        u_divisor = {lq_reg, 1'b0};
    end

    // Divide operand comes from the product of the same cycle.
    logic [srv_pkg::QW-1:0] dividend_now;
    logic [srv_pkg::OPW-1:0] u_operand_sel;
    assign dividend_now  = {1'b0, mul_p[33:0], 4'd0} + {10'd0, lq_reg};
    assign u_operand_sel = (state_reg == ST_SQL) ? u_operand
                         : {dividend_now, {(srv_pkg::OPW-srv_pkg::QW){1'b0}}};

    srv_iter_unit u_iter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (ucmd),
        .operand (u_operand_sel),
        .divisor (u_divisor),
        .done    (u_done),
        .result  (u_result)
    );

    // ---------------- direction and vertex logic ----------------
    logic [8:0]           p_sat;
    logic signed [DW-1:0] fdx, fdy, bdx, bdy;
    logic [DW-1:0]        abs_x, abs_y;
    logic                 dzero, big;
    logic signed [SW-1:0] px, py, ox, oy, v0x, v0y, v1x, v1y;
    logic signed [SW-1:0] sat_hi, sat_lo;
    logic signed [CW-1:0] s0x, s0y, s1x, s1y;
    logic signed [19:0]   hw_sum;

    function automatic logic signed [CW-1:0] clip(input logic signed [SW-1:0] v,
                                                  input logic signed [SW-1:0] hi,
                                                  input logic signed [SW-1:0] lo);
        if (v > hi)
            clip = hi[CW-1:0];
        else if (v < lo)
            clip = lo[CW-1:0];
        else
            clip = v[CW-1:0];
    endfunction

    always_comb
    begin
        p_sat = (pressure > srv_pkg::PRESS_FULL) ? srv_pkg::PRESS_FULL : pressure;
        fdx   = DW'(point_x) - DW'(held_x_reg);
        fdy   = DW'(point_y) - DW'(held_y_reg);
        bdx   = DW'(held_x_reg) - DW'(prior_x_reg);
        bdy   = DW'(held_y_reg) - DW'(prior_y_reg);
        dzero = (dx_reg == '0) && (dy_reg == '0);
        abs_x = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        abs_y = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        big   = (|ax_reg[MW-1:srv_pkg::MAG_W]) || (|ay_reg[MW-1:srv_pkg::MAG_W]);
        hw_sum = $signed({2'b00, min_width_reg, 8'd0}) + prod_reg[19:0];

        sat_hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        sat_lo = ~sat_hi;
        px  = SW'(pt_x_reg);
        py  = SW'(pt_y_reg);
        ox  = negx_reg ? -$signed({2'b00, qx_reg}) : $signed({2'b00, qx_reg});
        oy  = negy_reg ? -$signed({2'b00, qy_reg}) : $signed({2'b00, qy_reg});
        v0x = px + ox;
        v0y = py + oy;
        v1x = px - ox;
        v1y = py - oy;
        s0x = clip(v0x, sat_hi, sat_lo);
        s0y = clip(v0y, sat_hi, sat_lo);
        s1x = clip(v1x, sat_hi, sat_lo);
        s1y = clip(v1y, sat_hi, sat_lo);
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            seen_reg    <= 2'd0;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            held_p_reg  <= '0;
            prior_x_reg <= '0;
            prior_y_reg <= '0;
            ovalid_reg  <= 1'b0;
            job2_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_x_reg   <= point_x;
                        in_y_reg   <= point_y;
                        in_p_reg   <= p_sat;
                        in_end_reg <= stroke_end;
                        if (seen_reg == 2'd0)
                        begin
                            if (!stroke_end)
                            begin
                                held_x_reg <= point_x;
                                held_y_reg <= point_y;
                                held_p_reg <= p_sat;
                                seen_reg   <= 2'd1;
                            end
                        end
                        else
                        begin
                            pt_x_reg      <= held_x_reg;
                            pt_y_reg      <= held_y_reg;
                            pt_p_reg      <= held_p_reg;
                            run_end_reg   <= !stroke_end;
                            done_flag_reg <= 1'b0;
                            job2_reg      <= stroke_end;
                            if (fdx == '0 && fdy == '0 && seen_reg[1])
                            begin
                                dx_reg <= bdx;
                                dy_reg <= bdy;
                            end
                            else
                            begin
                                dx_reg <= fdx;
                                dy_reg <= fdy;
                            end
                            state_reg <= ST_DIR;
                        end
                    end
                end
                ST_DIR:
                begin
                    negx_reg  <= !dy_reg[DW-1] && (dy_reg != '0);
                    negy_reg  <= dx_reg[DW-1];
                    ax_reg    <= dzero ? MW'(1) : MW'(abs_x);
                    ay_reg    <= MW'(abs_y);
                    state_reg <= ST_RED;
                end
                ST_RED:
                begin
                    if (big)
                    begin
                        ax_reg <= ax_reg >> 1;
                        ay_reg <= ay_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= ST_MHW;
                    end
                end
                ST_MHW:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MXX;
                end
                ST_MXX:
                begin
                    hw_reg    <= hw_sum[srv_pkg::HW_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_MYY;
                end
                ST_MYY:
                begin
                    acc_reg   <= prod_reg[31:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQL;
                end
                ST_SQL:
                begin
                    state_reg <= ST_SQW;
                end
                ST_SQW:
                begin
                    if (u_done)
                    begin
                        lq_reg <= (u_result[srv_pkg::LQW-1:0] == '0)
                                ? srv_pkg::LQW'(1) : u_result[srv_pkg::LQW-1:0];
                        state_reg <= ST_MY;
                    end
                end
                ST_MY:
                begin
                    state_reg <= ST_DVYW;
                end
                ST_DVYW:
                begin
                    if (u_done)
                    begin
                        qx_reg    <= u_result;
                        state_reg <= ST_MX;
                    end
                end
                ST_MX:
                begin
                    state_reg <= ST_DVXW;
                end
                ST_DVXW:
                begin
                    if (u_done)
                    begin
                        qy_reg    <= u_result;
                        state_reg <= ST_EM0;
                    end
                end
                ST_EM0:
                begin
                    vx_reg     <= s0x;
                    vy_reg     <= s0y;
                    side_reg   <= 1'b0;
                    last_reg   <= 1'b0;
                    sdone_reg  <= 1'b0;
                    ovalid_reg <= 1'b1;
                    state_reg  <= ST_EM1;
                end
                ST_EM1:
                begin
                    if (out_ready)
                    begin
                        vx_reg    <= s1x;
                        vy_reg    <= s1y;
                        side_reg  <= 1'b1;
                        last_reg  <= run_end_reg;
                        sdone_reg <= done_flag_reg;
                        state_reg <= ST_EM2;
                    end
                end
                ST_EM2:
                begin
                    if (out_ready)
                    begin
                        ovalid_reg <= 1'b0;
                        if (job2_reg)
                        begin
                            pt_x_reg      <= in_x_reg;
                            pt_y_reg      <= in_y_reg;
                            pt_p_reg      <= in_p_reg;
                            dx_reg        <= DW'(in_x_reg) - DW'(held_x_reg);
                            dy_reg        <= DW'(in_y_reg) - DW'(held_y_reg);
                            run_end_reg   <= 1'b1;
                            done_flag_reg <= 1'b1;
                            job2_reg      <= 1'b0;
                            state_reg     <= ST_DIR;
                        end
                        else
                        begin
                            if (in_end_reg)
                            begin
                                held_x_reg  <= '0;
                                held_y_reg  <= '0;
                                held_p_reg  <= '0;
                                prior_x_reg <= '0;
                                prior_y_reg <= '0;
                                seen_reg    <= 2'd0;
                            end
                            else
                            begin
                                prior_x_reg <= held_x_reg;
                                prior_y_reg <= held_y_reg;
                                held_x_reg  <= in_x_reg;
                                held_y_reg  <= in_y_reg;
                                held_p_reg  <= in_p_reg;
                                seen_reg    <= 2'd2;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = ovalid_reg;
    assign vertex_x    = vx_reg;
    assign vertex_y    = vy_reg;
    assign side        = side_reg;
    assign last_of_run = last_reg;
    assign strip_done  = sdone_reg;

`ifndef ASSERT_OFF
    a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("request accepted while a vertex is pending");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && strip_done) |-> (last_of_run && side))
        else $error("strip end not on closing vertex");

    a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> (state_reg == ST_SQW || state_reg == ST_DVYW || state_reg == ST_DVXW))
        else $error("unit finished outside a wait state");

    a_seen_code: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("point count code invalid");
`endif

endmodule

[src/srv_iter_unit.sv]
// ----------------------------------------------------------------------------
// Iterative root / divide unit
// Restoring square root (two radicand bits per cycle) or restoring division
// (one dividend bit per cycle) sharing one compare and subtract.
// ----------------------------------------------------------------------------
module srv_iter_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  srv_pkg::unit_cmd_t           cmd,
    input  logic [srv_pkg::OPW-1:0]      operand,
    input  logic [srv_pkg::DVW-1:0]      divisor,
    output logic                         done,
    output logic [srv_pkg::QW-1:0]       result
);

    logic [srv_pkg::OPW-1:0]   opnd_reg;
    logic [srv_pkg::RW-1:0]    rem_reg;
    logic [srv_pkg::QW-1:0]    res_reg;
    logic [srv_pkg::DVW-1:0]   dvs_reg;
    logic [srv_pkg::CNT_W-1:0] cnt_reg;
    logic                      mode_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [srv_pkg::RW-1:0]    shifted;
    logic [srv_pkg::RW-1:0]    sub;
    logic [srv_pkg::RW:0]      diff;
    logic                      ge;

    always_comb
    begin
        if (mode_reg)
        begin
            shifted = {rem_reg[srv_pkg::RW-3:0], opnd_reg[srv_pkg::OPW-1 -: 2]};
            sub     = {res_reg[srv_pkg::RW-3:0], 2'b01};
        end
        else
        begin
            shifted = {rem_reg[srv_pkg::RW-2:0], opnd_reg[srv_pkg::OPW-1]};
            sub     = {{(srv_pkg::RW-srv_pkg::DVW){1'b0}}, dvs_reg};
        end
        diff = {1'b0, shifted} - {1'b0, sub};
        ge   = !diff[srv_pkg::RW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                mode_reg <= cmd.sqrt_mode;
                cnt_reg  <= (cmd.sqrt_mode ? srv_pkg::SQ_STEPS : srv_pkg::DV_STEPS) - 6'd1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            opnd_reg <= operand;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            res_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[srv_pkg::RW-1:0] : shifted;
            res_reg  <= {res_reg[srv_pkg::QW-2:0], ge};
            opnd_reg <= mode_reg ? {opnd_reg[srv_pkg::OPW-3:0], 2'b00}
                                 : {opnd_reg[srv_pkg::OPW-2:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
